>>> hw/rtl/rqts_pkg.sv
// ----------------------------------------------------------------------------
// Ready-queue timer scheduler package
// Shared widths, request and status codes and sequencer states.
// ----------------------------------------------------------------------------
package rqts_pkg;

  localparam int unsigned TASK_ID_W = 8;
  localparam int unsigned TICKS_W   = 16;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned OP_W      = 2;

  typedef enum logic [OP_W-1:0] {
    OP_SPAWN    = 2'd0,
    OP_SLEEP    = 2'd1,
    OP_DISPATCH = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPTED      = 3'd0,
    ST_DISPATCHED    = 3'd1,
    ST_IDLE          = 3'd2,
    ST_READY_FULL    = 3'd3,
    ST_TIMERS_FULL   = 3'd4,
    ST_NOT_SUSPENDED = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MOVE,
    S_SCAN,
    S_POP,
    S_POP_WAIT
  } state_t;

endpackage

>>> hw/rtl/rqts_ram.sv
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rqts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/ready_queue_timer_scheduler_unit.sv
// ----------------------------------------------------------------------------
// Ready-queue timer scheduler
// Ready FIFO of task numbers, a table of sleeping tasks with wake times and
// a virtual clock, driven by spawn, sleep and dispatch requests.
//
//   channel   handshake        payload
//   request   start / busy     operation, task_id, sleep_ticks
//   result    done (strobe)    status, dispatched_task, current_tick
//
// Spawn, sleep and ignored requests finish in S_EXEC. A dispatch walks the
// sleeper table through its single read port, one slot per cycle: a move
// pass, an earliest-wake scan and second move pass if the ready FIFO is empty
// but sleepers remain, and a FIFO pop. busy is low again in the cycle in which
// done is high. Reset is synchronous and clears all counters and the clock;
// results cannot be stalled.
// ----------------------------------------------------------------------------
module ready_queue_timer_scheduler_unit #(
  parameter int unsigned READY_DEPTH   = 16,
  parameter int unsigned SLEEPER_SLOTS = 16,
  parameter int unsigned TASK_BITS     = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [rqts_pkg::OP_W-1:0]      operation,
  input  logic [rqts_pkg::TASK_ID_W-1:0] task_id,
  input  logic signed [rqts_pkg::TICKS_W-1:0] sleep_ticks,
  output logic                           done,
  output logic [rqts_pkg::STATUS_W-1:0]  status,
  output logic [rqts_pkg::TASK_ID_W-1:0] dispatched_task,
  output logic [rqts_pkg::TIME_W-1:0]    current_tick
);

  import rqts_pkg::*;

  localparam int unsigned TaskW = (TASK_BITS < TASK_ID_W) ? TASK_BITS : TASK_ID_W;
  localparam int unsigned RAW   = $clog2(READY_DEPTH);
  localparam int unsigned RCW   = $clog2(READY_DEPTH + 1);
  localparam int unsigned SIW   = $clog2(SLEEPER_SLOTS);
  localparam int unsigned SCW   = $clog2(SLEEPER_SLOTS + 1);
  localparam int unsigned SLW   = TIME_W + TaskW;

  state_t state, state_next;

  op_t                      cmd_op;
  logic [TaskW-1:0]         cmd_task;
  logic signed [TICKS_W-1:0] cmd_ticks;

  logic [RAW-1:0]    ready_head, ready_head_next;
  logic [RAW-1:0]    ready_tail, ready_tail_next;
  logic [RCW-1:0]    ready_count, ready_count_next;
  logic [SCW-1:0]    sleeper_count, sleeper_count_next;
  logic [TIME_W-1:0] virtual_time, virtual_time_next;
  logic [SCW-1:0]    scan_rd, scan_rd_next;
  logic [SCW-1:0]    scan_wr, scan_wr_next;
  logic              pend, pend_next;
  logic              second_pass, second_pass_next;
  logic [TIME_W-1:0] best_time, best_time_next;

  logic              out_load;
  status_t           res_status;
  logic [TaskW-1:0]  res_task;

  logic              rq_we, rq_re;
  logic [RAW-1:0]    rq_waddr;
  logic [TaskW-1:0]  rq_wdata, rq_rdata;
  logic              sl_we, sl_re;
  logic [SIW-1:0]    sl_waddr, sl_raddr;
  logic [SLW-1:0]    sl_wdata, sl_rdata;

  logic [TIME_W-1:0] sl_wake;
  logic [TaskW-1:0]  sl_task;
  logic              rq_full;
  logic [RAW-1:0]    tail_inc, head_inc;
  logic              more_to_read, pass_end, need_jump, ticks_pos;
  logic [TIME_W:0]   wake_sum;
  logic [TIME_W-1:0] wake_sat;

  assign busy         = (state != S_IDLE);
  assign sl_wake      = sl_rdata[TaskW +: TIME_W];
  assign sl_task      = sl_rdata[TaskW-1:0];
  assign rq_full      = (ready_count == RCW'(READY_DEPTH));
  assign tail_inc     = (ready_tail == RAW'(READY_DEPTH - 1)) ? '0 : ready_tail + RAW'(1);
  assign head_inc     = (ready_head == RAW'(READY_DEPTH - 1)) ? '0 : ready_head + RAW'(1);
  assign more_to_read = (scan_rd < sleeper_count);
  assign pass_end     = !pend && !more_to_read;
  assign need_jump    = !second_pass && (ready_count == '0) && (scan_wr != '0);
  assign ticks_pos    = !cmd_ticks[TICKS_W-1] && (cmd_ticks != '0);
  assign wake_sum     = {1'b0, virtual_time} + (TIME_W+1)'(cmd_ticks[TICKS_W-2:0]);
  assign wake_sat     = wake_sum[TIME_W] ? {TIME_W{1'b1}} : wake_sum[TIME_W-1:0];

  rqts_ram #(
    .WIDTH (TaskW),
    .DEPTH (READY_DEPTH)
  ) u_ready_ram (
    .clk     (clk),
    .wr_en   (rq_we),
    .wr_addr (rq_waddr),
    .wr_data (rq_wdata),
    .rd_en   (rq_re),
    .rd_addr (ready_head),
    .rd_data (rq_rdata)
  );

  rqts_ram #(
    .WIDTH (SLW),
    .DEPTH (SLEEPER_SLOTS)
  ) u_sleeper_ram (
    .clk     (clk),
    .wr_en   (sl_we),
    .wr_addr (sl_waddr),
    .wr_data (sl_wdata),
    .rd_en   (sl_re),
    .rd_addr (sl_raddr),
    .rd_data (sl_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = (cmd_op == OP_DISPATCH) ? S_MOVE : S_IDLE;
      end
      S_MOVE: begin
        if (pass_end) begin
          state_next = need_jump ? S_SCAN : S_POP;
        end
      end
      S_SCAN: begin
        if (pass_end) begin
          state_next = S_MOVE;
        end
      end
      S_POP: begin
        state_next = (ready_count != '0) ? S_POP_WAIT : S_IDLE;
      end
      S_POP_WAIT: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ready_head_next    = ready_head;
    ready_tail_next    = ready_tail;
    ready_count_next   = ready_count;
    sleeper_count_next = sleeper_count;
    virtual_time_next  = virtual_time;
    scan_rd_next       = scan_rd;
    scan_wr_next       = scan_wr;
    pend_next          = pend;
    second_pass_next   = second_pass;
    best_time_next     = best_time;
    out_load           = 1'b0;
    res_status         = ST_IDLE;
    res_task           = '0;
    rq_we              = 1'b0;
    rq_re              = 1'b0;
    rq_waddr           = ready_tail;
    rq_wdata           = cmd_task;
    sl_we              = 1'b0;
    sl_re              = 1'b0;
    sl_waddr           = sleeper_count[SIW-1:0];
    sl_wdata           = {wake_sat, cmd_task};
    sl_raddr           = scan_rd[SIW-1:0];
    unique case (state)
      S_IDLE: begin
      end
      S_EXEC: begin
        unique case (cmd_op)
          OP_SPAWN: begin
            out_load = 1'b1;
            if (rq_full) begin
              res_status = ST_READY_FULL;
            end else begin
              rq_we            = 1'b1;
              ready_tail_next  = tail_inc;
              ready_count_next = ready_count + RCW'(1);
              res_status       = ST_ACCEPTED;
            end
          end
          OP_SLEEP: begin
            out_load = 1'b1;
            if (!ticks_pos) begin
              res_status = ST_NOT_SUSPENDED;
            end else if (sleeper_count == SCW'(SLEEPER_SLOTS)) begin
              res_status = ST_TIMERS_FULL;
            end else begin
              sl_we              = 1'b1;
              sleeper_count_next = sleeper_count + SCW'(1);
              res_status         = ST_ACCEPTED;
            end
          end
          OP_DISPATCH: begin
            scan_rd_next     = '0;
            scan_wr_next     = '0;
            pend_next        = 1'b0;
            second_pass_next = 1'b0;
          end
          OP_NONE: begin
            out_load = 1'b1;
          end
          default: begin
            out_load = 1'b1;
          end
        endcase
      end
      S_MOVE: begin
        if (pend) begin
          if ((sl_wake <= virtual_time) && !rq_full) begin
            rq_we            = 1'b1;
            rq_wdata         = sl_task;
            ready_tail_next  = tail_inc;
            ready_count_next = ready_count + RCW'(1);
          end else begin
            sl_we        = 1'b1;
            sl_waddr     = scan_wr[SIW-1:0];
            sl_wdata     = sl_rdata;
            scan_wr_next = scan_wr + SCW'(1);
          end
        end
        if (more_to_read) begin
          sl_re        = 1'b1;
          scan_rd_next = scan_rd + SCW'(1);
        end
        pend_next = more_to_read;
        if (pass_end) begin
          sleeper_count_next = scan_wr;
          scan_rd_next       = '0;
          best_time_next     = {TIME_W{1'b1}};
        end
      end
      S_SCAN: begin
        if (pend && (sl_wake < best_time)) begin
          best_time_next = sl_wake;
        end
        if (more_to_read) begin
          sl_re        = 1'b1;
          scan_rd_next = scan_rd + SCW'(1);
        end
        pend_next = more_to_read;
        if (pass_end) begin
          virtual_time_next = best_time;
          second_pass_next  = 1'b1;
          scan_rd_next      = '0;
          scan_wr_next      = '0;
        end
      end
      S_POP: begin
        if (ready_count != '0) begin
          rq_re = 1'b1;
        end else begin
          out_load   = 1'b1;
          res_status = ST_IDLE;
        end
      end
      S_POP_WAIT: begin
        out_load         = 1'b1;
        res_status       = ST_DISPATCHED;
        res_task         = rq_rdata;
        ready_head_next  = head_inc;
        ready_count_next = ready_count - RCW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      ready_head    <= '0;
      ready_tail    <= '0;
      ready_count   <= '0;
      sleeper_count <= '0;
      virtual_time  <= '0;
      scan_rd       <= '0;
      scan_wr       <= '0;
      pend          <= 1'b0;
      second_pass   <= 1'b0;
      done          <= 1'b0;
    end else begin
      state         <= state_next;
      ready_head    <= ready_head_next;
      ready_tail    <= ready_tail_next;
      ready_count   <= ready_count_next;
      sleeper_count <= sleeper_count_next;
      virtual_time  <= virtual_time_next;
      scan_rd       <= scan_rd_next;
      scan_wr       <= scan_wr_next;
      pend          <= pend_next;
      second_pass   <= second_pass_next;
      done          <= out_load;
    end
  end

  always_ff @(posedge clk) begin
    best_time <= best_time_next;
    if (start && !busy) begin
      cmd_op    <= op_t'(operation);
      cmd_task  <= task_id[TaskW-1:0];
      cmd_ticks <= sleep_ticks;
    end
    if (out_load) begin
      status          <= res_status;
      dispatched_task <= TASK_ID_W'(res_task);
      current_tick    <= virtual_time;
    end
  end

  a_ready_bound: assert property (@(posedge clk) disable iff (rst)
    ready_count <= RCW'(READY_DEPTH))
    else $error("ready count exceeds FIFO depth");

  a_sleeper_bound: assert property (@(posedge clk) disable iff (rst)
    sleeper_count <= SCW'(SLEEPER_SLOTS))
    else $error("sleeper count exceeds table size");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while a request is still in progress");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted request did not make the block busy");

endmodule
